// ===== hdl/sol_pkg.sv =====
package sol_pkg;

  // Fixed field widths of the request and result items
  localparam int KEY_WIDTH     = 16;
  localparam int REQ_W         = 2;
  localparam int POS_W         = 7;
  localparam int COUNT_W       = 8;
  localparam int DEPTH_DEFAULT = 128;

  // Request codes; the fourth code is an unused no-op
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2
  } req_e;

  // Reordering policy on a find hit
  localparam logic POL_MTF       = 1'b0;
  localparam logic POL_TRANSPOSE = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [KEY_WIDTH-1:0] key;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic               overflow;
    logic [COUNT_W-1:0] list_count;
  } rsp_t;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic                 cmp;
    logic                 upd;
    logic [REQ_W-1:0]     op;
    logic                 policy;
    logic                 found;
    logic [KEY_WIDTH-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== hdl/sol_cell.sv =====
// One slot of the list: holds a key, its occupancy and the registered compare
module sol_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sol_pkg::cell_ctrl_t           ctrl_i,
  input  logic [sol_pkg::KEY_WIDTH-1:0] prev_entry_i,
  input  logic                          prev_valid_i,
  input  logic [sol_pkg::KEY_WIDTH-1:0] next_entry_i,
  input  logic                          next_valid_i,
  input  logic                          pre_i,
  input  logic                          first_i,
  input  logic                          first_next_i,
  output logic [sol_pkg::KEY_WIDTH-1:0] entry_o,
  output logic                          valid_o,
  output logic                          match_o
);

  logic [sol_pkg::KEY_WIDTH-1:0] entry_q, entry_d;
  logic                          valid_q, valid_d;
  logic                          match_q, match_d;

  // Compare while cmp is set; shift, swap or load while upd is set
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = valid_q && (entry_q == ctrl_i.key);
    end
    if (ctrl_i.upd) begin
      case (ctrl_i.op)
        sol_pkg::REQ_INSERT: begin
          // tail slot: first empty one behind an occupied one
          if (!valid_q && prev_valid_i) begin
            entry_d = ctrl_i.key;
            valid_d = 1'b1;
          end
        end
        sol_pkg::REQ_DELETE: begin
          // at or behind the hit, pull from the successor
          if (pre_i || first_i) begin
            entry_d = next_entry_i;
            valid_d = next_valid_i;
          end
        end
        sol_pkg::REQ_FIND: begin
          if (ctrl_i.policy == sol_pkg::POL_MTF) begin
            // up to and including the hit, shift back by one
            if (ctrl_i.found && !pre_i) begin
              entry_d = prev_entry_i;
            end
          end else begin
            // swap the hit with its predecessor
            if (first_i) begin
              entry_d = prev_entry_i;
            end else if (first_next_i) begin
              entry_d = ctrl_i.key;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

// ===== hdl/sol_scan.sv =====
// First-match search over the registered compare bits of the chain
module sol_scan #(
  parameter int DEPTH = sol_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0] match_i,
  output logic [DEPTH-1:0] pre_o,
  output logic [DEPTH-1:0] first_o,
  output logic             found_o,
  output logic [IDX_W-1:0] pos_o
);

  localparam int LVL = $clog2(DEPTH);

  logic [DEPTH-1:0] lvl [LVL+1];

  // Log-depth prefix OR: lvl[LVL][i] is set when any slot up to i matches
  always_comb begin
    lvl[0] = match_i;
    for (int l = 0; l < LVL; l++) begin
      lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
    end
  end

  assign pre_o   = lvl[LVL] << 1;
  assign first_o = match_i & ~pre_o;
  assign found_o = |match_i;

  // One-hot to index
  always_comb begin
    pos_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_o[i]) begin
        pos_o = pos_o | IDX_W'(i);
      end
    end
  end

endmodule

// ===== hdl/self_organizing_list.sv =====
// Channel  Dir  Payload          Handshake
// in       in   sol_pkg::req_t   in_valid_i / in_stall_o
// out      out  sol_pkg::rsp_t   out_valid_o / out_stall_i
// cfg      in   policy (1 bit)   cfg_we_i, written at once
//
// Each request passes a compare state, to compare the key in every cell at once,
// and an update state: find the first hit, then shift by one slot, swap or load cells.
// The next request is taken in the cycle its predecessor finishes.
// A stalled result holds the chain in its update cycle until the slot frees.
// Reset empties the list (occupancy bits only) and selects move-to-front.
module self_organizing_list #(
  parameter int DEPTH = sol_pkg::DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sol_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sol_pkg::rsp_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e                        state_q, state_d;
  sol_pkg::req_t                 req_q, req_d;
  logic                          policy_q;
  logic [CNT_W-1:0]              len_q, len_d;
  logic                          out_valid_q, out_valid_d;
  sol_pkg::rsp_t                 out_q, out_d;

  logic                          can_finish;
  logic                          accept;
  logic                          apply;
  logic                          full;
  logic                          is_insert;
  logic                          is_search;
  sol_pkg::cell_ctrl_t           ctrl;

  logic [sol_pkg::KEY_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]              valid;
  logic [DEPTH-1:0]              match;
  logic [DEPTH-1:0]              pre;
  logic [DEPTH-1:0]              first;
  logic                          hit;
  logic [IDX_W-1:0]              hit_pos;

  // Handshake
  assign can_finish = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_UPD) && can_finish));
  assign accept     = in_valid_i && !in_stall_o;
  assign apply      = (state_q == S_UPD) && can_finish;

  assign full      = (len_q == CNT_W'(DEPTH));
  assign is_insert = (req_q.req_type == sol_pkg::REQ_INSERT);
  assign is_search = (req_q.req_type == sol_pkg::REQ_DELETE) ||
                     (req_q.req_type == sol_pkg::REQ_FIND);

  // Broadcast to the cells
  always_comb begin
    ctrl.cmp    = (state_q == S_CMP);
    ctrl.upd    = apply;
    ctrl.op     = req_q.req_type;
    ctrl.policy = policy_q;
    ctrl.found  = hit;
    ctrl.key    = req_q.key;
  end

  // Chain of cells; slot 0 sees the request key as its predecessor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [sol_pkg::KEY_WIDTH-1:0] prev_entry, next_entry;
    logic                          prev_valid, next_valid, first_next;
    if (i == 0) begin : g_head
      assign prev_entry = req_q.key;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_entry = entry[i-1];
      assign prev_valid = valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = '0;
      assign next_valid = 1'b0;
      assign first_next = 1'b0;
    end else begin : g_body
      assign next_entry = entry[i+1];
      assign next_valid = valid[i+1];
      assign first_next = first[i+1];
    end

    sol_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_entry_i (prev_entry),
      .prev_valid_i (prev_valid),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .pre_i        (pre[i]),
      .first_i      (first[i]),
      .first_next_i (first_next),
      .entry_o      (entry[i]),
      .valid_o      (valid[i]),
      .match_o      (match[i])
    );
  end

  sol_scan #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_scan (
    .match_i (match),
    .pre_o   (pre),
    .first_o (first),
    .found_o (hit),
    .pos_o   (hit_pos)
  );

  // Fill count after this request
  always_comb begin
    len_d = len_q;
    if (is_insert && !full) begin
      len_d = len_q + CNT_W'(1);
    end else if ((req_q.req_type == sol_pkg::REQ_DELETE) && hit) begin
      len_d = len_q - CNT_W'(1);
    end
  end

  // Sequencer and result register
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = in_data_i;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (apply) begin
          out_valid_d         = 1'b1;
          out_d.found         = is_search && hit;
          out_d.position      = (is_search && hit) ? sol_pkg::POS_W'(hit_pos) : '0;
          out_d.overflow      = is_insert && full;
          out_d.list_count    = sol_pkg::COUNT_W'(len_d);
          if (accept) begin
            req_d   = in_data_i;
            state_d = S_CMP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      policy_q    <= sol_pkg::POL_MTF;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (apply) begin
        len_q <= len_d;
      end
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/sol_checker.sv =====
// Port-level checks for the list
module sol_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sol_pkg::rsp_t out_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a request is busy in its compare cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("request taken during compare cycle");

  // after compare and update, a result is pending: this one or a stalled older one
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##3 out_valid_o)
    else $error("no result pending after compare and update");

  // a refused insert never reports a hit
  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |->
      (!out_data_o.found && (out_data_o.position == '0)))
    else $error("overflow result carries a hit");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind self_organizing_list sol_checker u_sol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int                         LIST_DEPTH  = sol_pkg::DEPTH_DEFAULT;
  localparam logic [sol_pkg::REQ_W-1:0]  REQ_UNUSED  = 2'd3;
  localparam int                         CYCLE_LIMIT = 400000;
  localparam int                         PHASE_ITEMS = 150;
  localparam int                         NUM_PHASES  = 8;
  localparam int                         SETTLE_CYC  = 6;

  // Tracks the list contents and holds the responses still owed by the DUT
  class list_tracker;
    logic [sol_pkg::KEY_WIDTH-1:0] keys[LIST_DEPTH];
    int unsigned                   count;
    logic                          policy;
    sol_pkg::rsp_t                 pending_rsp[$];
    int                            errors;

    function new();
      count  = 0;
      policy = sol_pkg::POL_MTF;
      errors = 0;
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction

    // Apply one request to the tracked list and return the response it yields
    function sol_pkg::rsp_t apply_request(sol_pkg::req_t req);
      sol_pkg::rsp_t rsp;
      int unsigned   idx;
      int unsigned   j;
      rsp = '0;
      case (req.req_type)
        sol_pkg::REQ_INSERT: begin
          if (count < LIST_DEPTH) begin
            keys[count] = req.key;
            count++;
          end else begin
            rsp.overflow = 1'b1;
          end
        end
        sol_pkg::REQ_DELETE, sol_pkg::REQ_FIND: begin
          // first match from the front
          idx = count;
          for (j = 0; j < count; j++) begin
            if (keys[j] == req.key) begin
              idx = j;
              break;
            end
          end
          if (idx < count) begin
            rsp.found    = 1'b1;
            rsp.position = idx[sol_pkg::POS_W-1:0];
            if (req.req_type == sol_pkg::REQ_DELETE) begin
              for (j = idx; j + 1 < count; j++) keys[j] = keys[j+1];
              count--;
            end else if (idx > 0) begin
              if (policy == sol_pkg::POL_MTF) begin
                for (j = idx; j > 0; j--) keys[j] = keys[j-1];
                keys[0] = req.key;
              end else begin
                keys[idx]   = keys[idx-1];
                keys[idx-1] = req.key;
              end
            end
          end
        end
        default: ;  // unused code: no-op
      endcase
      rsp.list_count = count[sol_pkg::COUNT_W-1:0];
      return rsp;
    endfunction

    function void note_request(sol_pkg::req_t req);
      pending_rsp.push_back(apply_request(req));
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(sol_pkg::rsp_t got);
      sol_pkg::rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response transfer: %p", got);
        errors++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      check_field("found", exp_rsp.found, got.found);
      check_field("position", exp_rsp.position, got.position);
      check_field("overflow", exp_rsp.overflow, got.overflow);
      check_field("list_count", exp_rsp.list_count, got.list_count);
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  sol_pkg::req_t in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  sol_pkg::rsp_t out_data_o;
  logic          cfg_we_i;
  logic          cfg_wdata_i;

  list_tracker sb;
  int          send_idle_pct;
  int          stall_pct;
  int          goal_len;
  int          full_hold;
  int unsigned cycle_count;

  self_organizing_list #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Response transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Entered and left just after a falling edge
  task automatic send_request(sol_pkg::req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic send_op(logic [sol_pkg::REQ_W-1:0] op,
                         logic [sol_pkg::KEY_WIDTH-1:0] k);
    sol_pkg::req_t req;
    req.req_type = op;
    req.key      = k;
    send_request(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_policy(logic pol);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pol;
    @(posedge clk_i);
    sb.policy = pol;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [sol_pkg::KEY_WIDTH-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return sol_pkg::KEY_WIDTH'($urandom_range(0, 47));
    if (r < 85) return sol_pkg::KEY_WIDTH'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Mostly a stored key, so finds and deletes hit at random depths
  function automatic logic [sol_pkg::KEY_WIDTH-1:0] pick_lookup_key();
    if (sb.count > 0 && $urandom_range(0, 99) < 80)
      return sb.keys[$urandom_range(0, sb.count - 1)];
    return pick_key();
  endfunction

  function automatic void pick_goal();
    case ($urandom_range(0, 9))
      0, 1:    goal_len = 0;
      2:       goal_len = 1;
      3:       goal_len = 2;
      4, 5:    goal_len = LIST_DEPTH;
      default: goal_len = $urandom_range(3, LIST_DEPTH - 1);
    endcase
    full_hold = 15;
  endfunction

  // Random traffic steering the fill level toward a moving target
  task automatic run_random(int n_items);
    int len;
    int ins_pct;
    int del_pct;
    int r;
    for (int i = 0; i < n_items; i++) begin
      len = sb.count;
      if (goal_len == LIST_DEPTH && len == LIST_DEPTH) begin
        full_hold--;
        if (full_hold <= 0) pick_goal();
      end else if (len == goal_len) begin
        pick_goal();
      end
      if (goal_len == LIST_DEPTH && len == LIST_DEPTH) ins_pct = 60;
      else if (len < goal_len)                        ins_pct = 85;
      else                                            ins_pct = 10;
      del_pct = (len > goal_len) ? 75 : 35;
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        send_op(sol_pkg::REQ_INSERT, pick_key());
      end else if ($urandom_range(0, 99) < 3) begin
        send_op(REQ_UNUSED, sol_pkg::KEY_WIDTH'($urandom_range(0, 16'hFFFF)));
      end else if ($urandom_range(0, 99) < del_pct) begin
        send_op(sol_pkg::REQ_DELETE, pick_lookup_key());
      end else begin
        send_op(sol_pkg::REQ_FIND, pick_lookup_key());
      end
      // hold off once until the pipe is empty
      if (send_idle_pct != 0 && stall_pct != 0 && i == n_items / 2) drain();
    end
  endtask

  initial begin
    logic pol;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    goal_len      = 0;
    full_hold     = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYC) @(negedge clk_i);

    // Directed: empty list, single entry, move-to-front
    write_policy(sol_pkg::POL_MTF);
    send_op(sol_pkg::REQ_FIND, 16'h1234);
    send_op(sol_pkg::REQ_DELETE, 16'hFFFF);
    send_op(REQ_UNUSED, 16'hFFFF);
    send_op(sol_pkg::REQ_INSERT, 16'h0000);
    send_op(sol_pkg::REQ_FIND, 16'h0000);
    send_op(sol_pkg::REQ_DELETE, 16'h0000);
    send_op(sol_pkg::REQ_INSERT, 16'hFFFF);
    send_op(sol_pkg::REQ_FIND, 16'hFFFF);
    send_op(sol_pkg::REQ_INSERT, 16'h0001);
    send_op(sol_pkg::REQ_INSERT, 16'h8000);
    send_op(sol_pkg::REQ_INSERT, 16'hAAAA);
    send_op(sol_pkg::REQ_INSERT, 16'h5555);
    send_op(sol_pkg::REQ_INSERT, 16'h0001);
    send_op(sol_pkg::REQ_FIND, 16'h5555);
    send_op(sol_pkg::REQ_FIND, 16'h5555);
    send_op(sol_pkg::REQ_FIND, 16'h0001);
    send_op(sol_pkg::REQ_FIND, 16'hBEEF);
    send_op(sol_pkg::REQ_DELETE, 16'h8000);
    send_op(REQ_UNUSED, 16'h0000);
    drain();

    // Directed: transpose, including a hit at the front
    write_policy(sol_pkg::POL_TRANSPOSE);
    send_op(sol_pkg::REQ_FIND, sb.keys[0]);
    send_op(sol_pkg::REQ_FIND, sb.keys[sb.count - 1]);
    send_op(sol_pkg::REQ_FIND, sb.keys[sb.count - 2]);
    send_op(sol_pkg::REQ_DELETE, sb.keys[0]);
    send_op(sol_pkg::REQ_DELETE, sb.keys[sb.count - 1]);
    send_op(sol_pkg::REQ_INSERT, 16'h7FFF);

    // Random phases over idle patterns and both policies
    pick_goal();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      pol = ((p + p / 4) % 2 != 0) ? sol_pkg::POL_TRANSPOSE : sol_pkg::POL_MTF;
      write_policy(pol);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 61; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      run_random(PHASE_ITEMS);
    end

    drain();
    stall_pct = 0;
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
